// ===== sv/partial_fraction_evaluator_top_assert.svh =====
// Assertion macros shared by the evaluator RTL.
`ifndef PARTIAL_FRACTION_EVALUATOR_TOP_ASSERT_SVH
`define PARTIAL_FRACTION_EVALUATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define PFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/pfe_pkg.sv =====
package pfe_pkg;

  // Data path: signed fixed point in 64 bits
  localparam int DATA_W        = 64;
  localparam int SLOT_W        = 5;
  localparam int COUNT_W       = 6;
  localparam int STATUS_W      = 2;
  localparam int CFG_IDX_W     = 1;
  // Term index / count width, enough for up to 256 terms
  localparam int IDX_W         = 9;

  localparam int MAX_TERMS_DEF = 32;
  localparam int FRAC_BITS_DEF = 48;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TERM_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONSTANT_TERM = 1'b1;

  // Item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_DIV = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  // Saturation values
  localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  // Request to the shared divider
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] rem;       // initial partial remainder, below divisor
    logic [DATA_W-1:0] dividend;  // low dividend word, shifted in MSB first
    logic [DATA_W-1:0] divisor;
  } pfe_div_req_t;

endpackage

// ===== sv/pfe_if.sv =====
// Input channel: load or evaluate transactions
interface pfe_in_if;
  import pfe_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [SLOT_W-1:0]        slot;
  logic signed [DATA_W-1:0] numerator_in;
  logic signed [DATA_W-1:0] pole_in;
  logic signed [DATA_W-1:0] x_value;

  modport source (output valid, mode, slot, numerator_in, pole_in, x_value, input ready);
  modport sink   (input valid, mode, slot, numerator_in, pole_in, x_value, output ready);
endinterface

// Result channel
interface pfe_out_if;
  import pfe_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

// ===== sv/partial_fraction_evaluator_top.sv =====
// Partial-fraction evaluator: r(x) = c0 + sum over k < n of a[k] / (x + b[k]), all values
// signed Q(63-FRAC_BITS).FRAC_BITS in 64 bits. A load transaction (mode 0) writes one
// numerator/pole pair into the term store and returns no result; loads to
// slots at or above MAX_TERMS are dropped. An evaluate transaction (mode 1) walks terms
// 0..n-1, n = min(term_count, MAX_TERMS), through one shared radix-2 divider and returns
// one result. Each divided term passes the divider's 64 one-bit steps, its done flag and
// the sequencer steps (store read, divisor form, sign check, range check, quotient check,
// accumulate). The result waits while the previous result is still held at the output;
// the block is not ready while it runs. A zero divisor stops the walk with a saturated
// value and status 1; a quotient or sum outside the 64-bit range stops it with status 2.
// Evaluating terms that were never loaded gives undefined values. Configuration must be
// written only while the block is idle; the block itself does not enforce this.
`include "partial_fraction_evaluator_top_assert.svh"

module partial_fraction_evaluator_top #(
  parameter int MAX_TERMS = pfe_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = pfe_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pfe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pfe_pkg::DATA_W-1:0]      cfg_data,
  pfe_in_if.sink                          in_ch,
  pfe_out_if.source                       out_ch
);
  import pfe_pkg::*;

  localparam int AW    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int NSH   = DATA_W - FRAC_BITS;
  localparam int RAM_W = 2 * DATA_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FETCH, ST_SETUP, ST_CHECK, ST_PRECHK, ST_DIV, ST_QCHK, ST_ACC, ST_DONE
  } state_t;

  // Configuration registers
  logic [COUNT_W-1:0] term_count_r;
  logic [DATA_W-1:0]  const_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_count_r <= '0;
      const_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TERM_COUNT:    term_count_r <= cfg_data[COUNT_W-1:0];
        CFG_CONSTANT_TERM: const_r      <= cfg_data;
        default:           ;
      endcase
    end
  end

  // Sequencer state and registered outputs
  state_t              state_r, state_nxt;
  logic [DATA_W-1:0]   x_r, x_nxt;
  logic [DATA_W-1:0]   acc_r, acc_nxt;
  logic [IDX_W-1:0]    n_r, n_nxt;
  logic [IDX_W-1:0]    k_r, k_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [DATA_W:0]     d65_r, d65_nxt;
  logic [DATA_W-1:0]   a_r, a_nxt;
  logic                qneg_r, qneg_nxt;
  logic [DATA_W-1:0]   amag_r, amag_nxt;
  logic [DATA_W:0]     dmag_r, dmag_nxt;
  logic [DATA_W-1:0]   q_r, q_nxt;
  logic [DATA_W-1:0]   t_r, t_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_value_r, out_value_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  // Term store: {numerator, pole offset}
  logic              ram_we;
  logic [IDX_W-1:0]  slot_ext;
  logic [RAM_W-1:0]  ram_rdata;

  // Shared divider
  pfe_div_req_t      div_req;
  logic              div_done;
  logic [DATA_W-1:0] div_q;

  // Helpers
  logic              in_acc;
  logic [IDX_W-1:0]  tc_ext;
  logic [DATA_W-1:0] a_rd;
  logic [DATA_W-1:0] b_rd;
  logic              dneg;
  logic [DATA_W-1:0] nhi;
  logic [DATA_W-1:0] nlo;
  logic              big;
  logic              pre_ovf;
  logic [DATA_W-1:0] q_limit;
  logic [DATA_W-1:0] sum;
  logic              sum_ovf;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign slot_ext    = IDX_W'(in_ch.slot);
  assign ram_we      = in_acc && (in_ch.mode == MODE_LOAD) && (slot_ext < IDX_W'(MAX_TERMS));
  assign tc_ext      = IDX_W'(term_count_r);

  pfe_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_TERMS)
  ) u_terms (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_ext[AW-1:0]),
    .wdata ({in_ch.numerator_in, in_ch.pole_in}),
    .raddr (k_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  pfe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  // Data path terms used by the sequencer
  always_comb begin
    a_rd    = ram_rdata[RAM_W-1:DATA_W];
    b_rd    = ram_rdata[DATA_W-1:0];
    dneg    = d65_r[DATA_W];
    nhi     = amag_r >> NSH;
    nlo     = amag_r << FRAC_BITS;
    big     = dmag_r[DATA_W];
    // Quotient needs more than 64 bits exactly when nhi >= divisor
    pre_ovf = ({1'b0, nhi} >= dmag_r);
    q_limit = qneg_r ? SAT_NEG : SAT_POS;
    sum     = acc_r + t_r;
    sum_ovf = (acc_r[DATA_W-1] == t_r[DATA_W-1]) && (sum[DATA_W-1] != acc_r[DATA_W-1]);
  end

  // Sequencer next state
  always_comb begin
    state_nxt      = state_r;
    x_nxt          = x_r;
    acc_nxt        = acc_r;
    n_nxt          = n_r;
    k_nxt          = k_r;
    status_nxt     = status_r;
    d65_nxt        = d65_r;
    a_nxt          = a_r;
    qneg_nxt       = qneg_r;
    amag_nxt       = amag_r;
    dmag_nxt       = dmag_r;
    q_nxt          = q_r;
    t_nxt          = t_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    div_req.start    = 1'b0;
    div_req.rem      = nhi;
    div_req.dividend = nlo;
    div_req.divisor  = dmag_r[DATA_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_ch.mode == MODE_EVAL)) begin
          x_nxt      = in_ch.x_value;
          acc_nxt    = const_r;
          n_nxt      = (tc_ext > IDX_W'(MAX_TERMS)) ? IDX_W'(MAX_TERMS) : tc_ext;
          k_nxt      = '0;
          status_nxt = STATUS_OK;
          state_nxt  = ST_FETCH;
        end
      end
      // Store read of term k is issued here
      ST_FETCH: begin
        state_nxt = (k_r == n_r) ? ST_DONE : ST_SETUP;
      end
      // Exact 65-bit divisor
      ST_SETUP: begin
        d65_nxt   = {x_r[DATA_W-1], x_r} + {b_rd[DATA_W-1], b_rd};
        a_nxt     = a_rd;
        state_nxt = ST_CHECK;
      end
      // Signs, magnitudes and zero divisor
      ST_CHECK: begin
        amag_nxt = a_r[DATA_W-1] ? (DATA_W'(0) - a_r) : a_r;
        dmag_nxt = dneg ? ((DATA_W+1)'(0) - d65_r) : d65_r;
        qneg_nxt = a_r[DATA_W-1] != dneg;
        if (d65_r == '0) begin
          acc_nxt    = a_r[DATA_W-1] ? SAT_NEG : SAT_POS;
          status_nxt = STATUS_ZERO_DIV;
          state_nxt  = ST_DONE;
        end else begin
          state_nxt = ST_PRECHK;
        end
      end
      // Divisor of magnitude 2^64 gives nhi directly; otherwise range check and divide
      ST_PRECHK: begin
        if (big) begin
          q_nxt     = nhi;
          state_nxt = ST_QCHK;
        end else if (pre_ovf) begin
          acc_nxt    = qneg_r ? SAT_NEG : SAT_POS;
          status_nxt = STATUS_OVERFLOW;
          state_nxt  = ST_DONE;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          q_nxt     = div_q;
          state_nxt = ST_QCHK;
        end
      end
      // Quotient range and sign
      ST_QCHK: begin
        if (q_r > q_limit) begin
          acc_nxt    = qneg_r ? SAT_NEG : SAT_POS;
          status_nxt = STATUS_OVERFLOW;
          state_nxt  = ST_DONE;
        end else begin
          t_nxt     = qneg_r ? (DATA_W'(0) - q_r) : q_r;
          state_nxt = ST_ACC;
        end
      end
      // Accumulate with overflow check
      ST_ACC: begin
        if (sum_ovf) begin
          acc_nxt    = t_r[DATA_W-1] ? SAT_NEG : SAT_POS;
          status_nxt = STATUS_OVERFLOW;
          state_nxt  = ST_DONE;
        end else begin
          acc_nxt   = sum;
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_FETCH;
        end
      end
      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = acc_r;
          out_status_nxt = status_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r          <= x_nxt;
    acc_r        <= acc_nxt;
    n_r          <= n_nxt;
    k_r          <= k_nxt;
    status_r     <= status_nxt;
    d65_r        <= d65_nxt;
    a_r          <= a_nxt;
    qneg_r       <= qneg_nxt;
    amag_r       <= amag_nxt;
    dmag_r       <= dmag_nxt;
    q_r          <= q_nxt;
    t_r          <= t_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = out_value_r;
  assign out_ch.status = out_status_r;

  // Checks
  `PFE_ASSERT_IMPL(a_div_nonzero, clk, rst_n, div_req.start, (dmag_r != '0) && !big)
  `PFE_ASSERT_IMPL(a_done_in_div, clk, rst_n, div_done, state_r == ST_DIV)
  `PFE_ASSERT_IMPL(a_k_in_range, clk, rst_n, state_r != ST_IDLE, k_r <= n_r)
  `PFE_ASSERT_IMPL(a_ok_full_walk, clk, rst_n, (state_r == ST_DONE) && (status_r == STATUS_OK), k_r == n_r)
  `PFE_ASSERT_NEXT(a_result_out, clk, rst_n, (state_r == ST_DONE) && (state_nxt == ST_IDLE), out_ch.valid)

endmodule

// ===== sv/pfe_ram.sv =====
module pfe_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/pfe_div.sv =====
module pfe_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pfe_pkg::pfe_div_req_t       req,
  output logic                        done,
  output logic [pfe_pkg::DATA_W-1:0]  quotient
);
  import pfe_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] dq_r;    // dividend bits in, quotient bits out
  logic [DATA_W-1:0] den_r;

  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;
  logic              fits;

  // One restoring step: shift in the next dividend bit, trial subtract
  always_comb begin
    rem_sh = {rem_r, dq_r[DATA_W-1]};
    diff   = rem_sh - {1'b0, den_r};
    fits   = !diff[DATA_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= req.rem;
        dq_r   <= req.dividend;
        den_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= fits ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
        dq_r  <= {dq_r[DATA_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

// ===== tb/tb_partial_fraction_evaluator_top.sv =====
`timescale 1ns / 100ps

module tb_partial_fraction_evaluator_top;
  import pfe_pkg::*;

  localparam int MAX_TERMS = MAX_TERMS_DEF;
  localparam int FRAC = FRAC_BITS_DEF;
  localparam int ITEM_TARGET = 280;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT = 3_000_000;

  localparam logic [DATA_W-1:0] ONE = 64'd1 << FRAC;
  localparam logic [DATA_W-1:0] TWO = ONE << 1;

  typedef struct {
    logic              mode;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] numer;
    logic [DATA_W-1:0] pole;
    logic [DATA_W-1:0] x;
  } pfe_item_t;

  typedef struct {
    logic [DATA_W-1:0]   value;
    logic [STATUS_W-1:0] status;
  } eval_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  pfe_in_if  in_ch();
  pfe_out_if out_ch();

  partial_fraction_evaluator_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Predictor state: term store and register copies
  logic [DATA_W-1:0] numer_mem [MAX_TERMS];
  logic [DATA_W-1:0] pole_mem [MAX_TERMS];
  logic [COUNT_W-1:0] term_count_q;
  logic [DATA_W-1:0] c0_q;

  // Pole values as the generator expects them when each evaluation is sent
  logic [DATA_W-1:0] plan_pole [MAX_TERMS];

  pfe_item_t    send_backlog [$];
  eval_result_t predicted_values [$];
  pfe_item_t    cur_item;

  int  queued = 0;
  int  accepted = 0;
  int  errors = 0;
  int  cycle_count = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  calm_in = 0;
  bit  calm_out = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // r(x) = c0 + sum a[k] / (x + b[k]), walk stops at the first error
  function automatic eval_result_t eval_rational(input logic [DATA_W-1:0] x);
    eval_result_t      r;
    int unsigned       n;
    int unsigned       k;
    logic [DATA_W-1:0] acc;
    logic [DATA_W:0]   den;
    logic [DATA_W:0]   den_mag;
    logic [DATA_W-1:0] a_mag;
    logic [127:0]      quo;
    logic [DATA_W-1:0] term;
    logic [DATA_W:0]   sum;
    logic              a_neg;
    logic              q_neg;
    n = (term_count_q > MAX_TERMS) ? MAX_TERMS : term_count_q;
    acc = c0_q;
    r.status = STATUS_OK;
    for (k = 0; k < n; k++) begin
      den = {x[DATA_W-1], x} + {pole_mem[k][DATA_W-1], pole_mem[k]};
      a_neg = numer_mem[k][DATA_W-1];
      if (den == '0) begin
        acc = a_neg ? SAT_NEG : SAT_POS;
        r.status = STATUS_ZERO_DIV;
        break;
      end
      // magnitude of -2^64 comes out as 2^64 in 65 unsigned bits
      den_mag = den[DATA_W] ? (~den + 65'd1) : den;
      a_mag = a_neg ? (~numer_mem[k] + 64'd1) : numer_mem[k];
      quo = ({64'd0, a_mag} << FRAC) / {63'd0, den_mag};
      q_neg = a_neg ^ den[DATA_W];
      if (quo > {64'd0, (q_neg ? SAT_NEG : SAT_POS)}) begin
        acc = q_neg ? SAT_NEG : SAT_POS;
        r.status = STATUS_OVERFLOW;
        break;
      end
      term = q_neg ? (~quo[DATA_W-1:0] + 64'd1) : quo[DATA_W-1:0];
      sum = {acc[DATA_W-1], acc} + {term[DATA_W-1], term};
      if (sum[DATA_W] != sum[DATA_W-1]) begin
        acc = term[DATA_W-1] ? SAT_NEG : SAT_POS;
        r.status = STATUS_OVERFLOW;
        break;
      end
      acc = sum[DATA_W-1:0];
    end
    r.value = acc;
    return r;
  endfunction

  // Mostly zero, sometimes short, rarely long
  function automatic int idle_len(input bit calm);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (calm || p < 60) return 0;
    else if (p < 88) return $urandom_range(1, 3);
    else if (p < 98) return $urandom_range(4, 15);
    else return $urandom_range(20, 80);
  endfunction

  // Q15.48 operand: full range, scaled down, extremes or small integers
  function automatic logic [DATA_W-1:0] pick_word();
    int unsigned       p;
    logic [DATA_W-1:0] w;
    p = $urandom_range(0, 9);
    w = {$urandom, $urandom};
    if (p >= 4 && p < 8) begin
      w = $signed(w) >>> $urandom_range(8, 40);
    end else if (p == 8) begin
      case ($urandom_range(0, 4))
        0: w = SAT_POS;
        1: w = SAT_NEG;
        2: w = '0;
        3: w = ONE;
        default: w = -ONE;
      endcase
    end else if (p == 9) begin
      w = 64'($urandom_range(1, 8)) << FRAC;
      if ($urandom_range(0, 1)) w = -w;
    end
    return w;
  endfunction

  // Evaluation point: random, on a pole, or just beside one
  function automatic logic [DATA_W-1:0] pick_x();
    int unsigned n;
    int unsigned k;
    int unsigned p;
    n = (term_count_q > MAX_TERMS) ? MAX_TERMS : term_count_q;
    p = $urandom_range(0, 9);
    if (n == 0 || p > 1) return pick_word();
    k = $urandom_range(0, n - 1);
    if (p == 0) return ~plan_pole[k] + 64'd1;
    return ~plan_pole[k] + 64'd1 + 64'($urandom_range(0, 255)) - 64'd128;
  endfunction

  task automatic add_load(input logic [SLOT_W-1:0] slot, input logic [DATA_W-1:0] a,
                          input logic [DATA_W-1:0] b);
    pfe_item_t it;
    it.mode = MODE_LOAD;
    it.slot = slot;
    it.numer = a;
    it.pole = b;
    it.x = {$urandom, $urandom};
    send_backlog.push_back(it);
    if (slot < MAX_TERMS) plan_pole[slot] = b;
    queued++;
  endtask

  task automatic add_eval(input logic [DATA_W-1:0] x);
    pfe_item_t it;
    it.mode = MODE_EVAL;
    it.slot = SLOT_W'($urandom);
    it.numer = {$urandom, $urandom};
    it.pole = {$urandom, $urandom};
    it.x = x;
    send_backlog.push_back(it);
    queued++;
  endtask

  // Every transaction sent and every result back, then let loads settle
  task automatic wait_idle();
    while (accepted != queued || predicted_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TERM_COUNT) term_count_q = data[COUNT_W-1:0];
    else c0_q = data;
  endtask

  task automatic configure(input logic [COUNT_W-1:0] tc, input logic [DATA_W-1:0] c0);
    wait_idle();
    write_reg(CFG_TERM_COUNT, DATA_W'(tc));
    write_reg(CFG_CONSTANT_TERM, c0);
  endtask

  // Stimulus: directed corner cases, then randomized phases
  initial begin : stimulus
    int            i;
    int            j;
    int            tmp;
    int            phase;
    int unsigned   n_items;
    int unsigned   p;
    int            order [MAX_TERMS-4];
    logic [COUNT_W-1:0] tc;
    logic [DATA_W-1:0]  c0;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_LOAD;
    in_ch.slot = '0;
    in_ch.numerator_in = '0;
    in_ch.pole_in = '0;
    in_ch.x_value = '0;
    out_ch.ready = 1'b0;
    term_count_q = '0;
    c0_q = '0;
    for (i = 0; i < MAX_TERMS; i++) begin
      numer_mem[i] = '0;
      pole_mem[i] = '0;
      plan_pole[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // no terms: result is c0
    configure(6'd0, SAT_POS);
    add_load(5'd0, ONE, TWO);
    add_load(5'd1, SAT_NEG, ONE);
    add_load(5'd2, SAT_POS, SAT_NEG);
    add_load(5'd3, -ONE, 64'd0);
    add_eval(SAT_POS);

    // single term: plain, zero divisor, extreme x
    configure(6'd1, 64'd0);
    add_eval(64'd0);
    add_eval(-TWO);
    add_eval(SAT_NEG);
    add_eval(SAT_POS);

    // two terms: quotient of exactly -2^63, zero divisor with negative numerator,
    // quotient overflow
    configure(6'd2, 64'd0);
    add_eval(64'd0);
    add_eval(-TWO);
    add_eval(-ONE);
    add_eval(-(ONE + TWO));
    add_eval(-(ONE + (ONE >> 1)));

    // divisor of -2^64 and near-extreme divisors
    configure(6'd3, SAT_NEG);
    add_eval(SAT_NEG);
    add_eval(SAT_POS);

    // sum overflow in both directions
    configure(6'd1, SAT_POS - 64'd1);
    add_eval(64'd0);
    configure(6'd1, SAT_NEG);
    add_eval(-(ONE + TWO));

    // fill the remaining slots in random order with evaluations mixed in
    configure(COUNT_W'($urandom_range(0, 4)), pick_word());
    for (i = 0; i < MAX_TERMS - 4; i++) order[i] = i + 4;
    for (i = MAX_TERMS - 5; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (i = 0; i < MAX_TERMS - 4; i++) begin
      add_load(SLOT_W'(order[i]), pick_word(), pick_word());
      if ($urandom_range(0, 1)) add_eval(pick_x());
    end

    // random phases, each one with its own register setting
    phase = 1;
    while (queued < ITEM_TARGET) begin
      case (phase)
        1: tc = 6'd32;
        2: tc = 6'd63;
        3: tc = 6'd33;
        default: begin
          p = $urandom_range(0, 99);
          if (p < 50) tc = COUNT_W'($urandom_range(0, 4));
          else if (p < 80) tc = COUNT_W'($urandom_range(5, 16));
          else if (p < 92) tc = COUNT_W'($urandom_range(17, 32));
          else tc = COUNT_W'($urandom_range(33, 63));
        end
      endcase
      if (phase == 3) c0 = SAT_POS;
      else if (phase == 4) c0 = SAT_NEG;
      else c0 = pick_word();
      configure(tc, c0);
      n_items = $urandom_range(6, 18);
      repeat (n_items) begin
        if ($urandom_range(0, 3) == 0)
          add_load(SLOT_W'($urandom_range(0, 31)), pick_word(), pick_word());
        else
          add_eval(pick_x());
      end
      phase++;
    end

    wait_idle();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // Driver: one transaction at a time from the backlog, random gaps between
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (cur_item.mode == MODE_EVAL) begin
          predicted_values.push_back(eval_rational(cur_item.x));
        end else if (cur_item.slot < MAX_TERMS) begin
          numer_mem[cur_item.slot] = cur_item.numer;
          pole_mem[cur_item.slot] = cur_item.pole;
        end
        accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (send_backlog.size() > 0) begin
          cur_item = send_backlog.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.mode <= cur_item.mode;
          in_ch.slot <= cur_item.slot;
          in_ch.numerator_in <= cur_item.numer;
          in_ch.pole_in <= cur_item.pole;
          in_ch.x_value <= cur_item.x;
          if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
          gap_left = idle_len(calm_in);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest prediction, stall at random
  always @(posedge clk) begin
    eval_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_values.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: value %h status %0d", out_ch.value, out_ch.status);
        end else begin
          want = predicted_values.pop_front();
          if (out_ch.value !== want.value || out_ch.status !== want.status) begin
            errors++;
            if (errors <= 10)
              $display("result mismatch: value exp %h got %h, status exp %0d got %0d",
                       want.value, out_ch.value, want.status, out_ch.status);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) == 0) calm_out = !calm_out;
        stall_left = idle_len(calm_out);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
